>>> hw/rtl/ibb_pkg.sv
package ibb_pkg;

  // store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 10;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  // compaction limits
  localparam logic [WORD_W-1:0] NARROW_TOP  = 32'h0000_FFFF;
  localparam logic [WORD_W-1:0] NARROW_SPAN = 32'h0000_FFFE;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RESTART_VALUE = 3'd0,
    CFG_MAX_VERTEX    = 3'd1,
    CFG_CAPACITY      = 3'd2,
    CFG_RESTART_COMPAT = 3'd3,
    CFG_CLAMP_IN_RANGE = 3'd4
  } cfg_idx_t;

  // input actions
  typedef enum logic [2:0] {
    ACT_APPEND         = 3'd0,
    ACT_APPEND_RESTART = 3'd1,
    ACT_SET_AT         = 3'd2,
    ACT_RESTART_AT     = 3'd3,
    ACT_READ           = 3'd4,
    ACT_CLEAR          = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_VERTEX   = 2'd1,
    ST_POSITION = 2'd2
  } status_t;

  // configuration registers
  typedef struct packed {
    logic [WORD_W-1:0] restart_value;
    logic [WORD_W-1:0] max_vertex;
    logic [CNT_W-1:0]  capacity;
    logic              restart_compatible;
    logic              clamp_in_range;
  } cfg_t;

  // running summary of the stored words
  typedef struct packed {
    logic [CNT_W-1:0]  entry_total;
    logic [WORD_W-1:0] lowest_index;
    logic [WORD_W-1:0] highest_index;
    logic              restart_seen;
  } summary_t;

  // per-word outcome handed to the result stage
  typedef struct packed {
    status_t status;
    logic    read_ok;
  } step_t;

endpackage

>>> hw/rtl/ibb_ram.sv
module ibb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ibb_summary.sv
module ibb_summary import ibb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  action_t           action,
  input  logic [POS_W-1:0]  position,
  input  logic [WORD_W-1:0] vertex,
  input  cfg_t              cfg,
  output summary_t          summary,
  output step_t             step,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [WORD_W-1:0] mem_wdata
);

  summary_t         sum_r;
  summary_t         sum_nxt;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] slot;
  logic [CNT_W-1:0] slot_end;
  logic             slot_bad;
  logic             pos_bad;
  logic             vertex_bad;
  logic             do_write;

  // effective capacity and target slot
  assign lim        = (cfg.capacity > DEPTH_CNT) ? DEPTH_CNT : cfg.capacity;
  assign slot       = (action == ACT_APPEND || action == ACT_APPEND_RESTART) ?
                      sum_r.entry_total : CNT_W'(position);
  assign slot_end   = slot + CNT_W'(1);
  assign slot_bad   = slot >= lim;
  assign pos_bad    = CNT_W'(position) >= lim;
  assign vertex_bad = vertex > cfg.max_vertex;

  // action decode, status and next summary
  always_comb begin
    sum_nxt      = sum_r;
    step.status  = ST_OK;
    step.read_ok = 1'b0;
    do_write     = 1'b0;
    mem_wdata    = vertex;
    unique case (action)
      ACT_APPEND, ACT_SET_AT: begin
        if (vertex_bad) begin
          step.status = ST_VERTEX;
        end else if (slot_bad) begin
          step.status = ST_POSITION;
        end else begin
          do_write = 1'b1;
          if (vertex < sum_r.lowest_index) begin
            sum_nxt.lowest_index = vertex;
          end
          if (vertex > sum_r.highest_index) begin
            sum_nxt.highest_index = vertex;
          end
        end
      end
      ACT_APPEND_RESTART, ACT_RESTART_AT: begin
        mem_wdata = cfg.restart_value;
        if (slot_bad) begin
          step.status = ST_POSITION;
        end else begin
          do_write             = 1'b1;
          sum_nxt.restart_seen = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_bad) begin
          step.status = ST_POSITION;
        end else begin
          step.read_ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        sum_nxt.entry_total   = '0;
        sum_nxt.lowest_index  = '1;
        sum_nxt.highest_index = '0;
        sum_nxt.restart_seen  = 1'b0;
      end
      default: begin
      end
    endcase
    if (do_write && slot_end > sum_r.entry_total) begin
      sum_nxt.entry_total = slot_end;
    end
  end

  assign mem_we    = accept & do_write;
  assign mem_waddr = slot[ADDR_W-1:0];
  assign summary   = sum_r;

  // summary registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r.entry_total   <= '0;
      sum_r.lowest_index  <= '1;
      sum_r.highest_index <= '0;
      sum_r.restart_seen  <= 1'b0;
    end else if (accept) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

>>> hw/rtl/ibb_convert.sv
module ibb_convert import ibb_pkg::*; (
  input  summary_t          summary,
  input  cfg_t              cfg,
  input  logic              read_ok,
  input  logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] read_value,
  output logic              narrow_mode,
  output logic [WORD_W-1:0] index_base,
  output logic              is_empty
);

  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] delta;
  logic [WORD_W-1:0] top;
  logic [WORD_W-1:0] rebased;
  logic              span_pos;
  logic              rebase;

  // span of the stored indices; it wraps when lowest is above highest, hence span_pos
  assign span        = summary.highest_index - summary.lowest_index;
  assign span_pos    = summary.lowest_index < summary.highest_index;
  assign narrow_mode = !span_pos || (span <= NARROW_SPAN);
  assign rebase      = narrow_mode && (summary.highest_index >= NARROW_TOP);
  assign index_base  = rebase ? summary.lowest_index : '0;
  assign is_empty    = summary.lowest_index > summary.highest_index;

  // rebase on the minimum and clamp
  assign delta   = word - summary.lowest_index;
  assign top     = (cfg.restart_compatible || !cfg.clamp_in_range) ? NARROW_TOP : span;
  assign rebased = (delta < top) ? delta : top;

  // pick the converted word
  always_comb begin
    if (!read_ok) begin
      read_value = '0;
    end else if (!narrow_mode) begin
      read_value = word;
    end else if (rebase) begin
      read_value = rebased;
    end else begin
      read_value = {16'h0000, word[15:0]};
    end
  end

endmodule

>>> hw/rtl/index_buffer_builder_compactor_top.sv
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | in_action, in_position, in_vertex
// out      | out_valid / out_stall  | out_read_value, out_narrow_mode, out_index_base,
//          |                        | out_entry_count, out_is_empty, out_used_restart,
//          |                        | out_status
// cfg      | cfg_we                 | cfg_index, cfg_wdata
//
// For each word, the accept cycle updates the summary registers and issues the
// index memory access, and the next cycle converts the read data and loads the
// result register. One word is in flight at a time, so no new word is accepted
// until the previous one has loaded the result register.
// Synchronous active-low reset clears the summary and the handshake state; the
// index memory is not cleared. in_stall is high while a word is in flight or a
// finished result is held by out_stall.
module index_buffer_builder_compactor_top import ibb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [POS_W-1:0]  in_position,
  input  logic [WORD_W-1:0] in_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_read_value,
  output logic              out_narrow_mode,
  output logic [WORD_W-1:0] out_index_base,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_is_empty,
  output logic              out_used_restart,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_wdata
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t            state_r;
  cfg_t              cfg_r;
  step_t             step_r;
  step_t             step;
  summary_t          summary;
  logic              accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] conv_value;
  logic              conv_narrow;
  logic [WORD_W-1:0] conv_base;
  logic              conv_empty;
  logic              out_valid_r;

  // input handshake
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.restart_value      <= '1;
      cfg_r.max_vertex         <= '1;
      cfg_r.capacity           <= DEPTH_CNT;
      cfg_r.restart_compatible <= 1'b1;
      cfg_r.clamp_in_range     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RESTART_VALUE:  cfg_r.restart_value      <= cfg_wdata;
        CFG_MAX_VERTEX:     cfg_r.max_vertex         <= cfg_wdata;
        CFG_CAPACITY:       cfg_r.capacity           <= cfg_wdata[CNT_W-1:0];
        CFG_RESTART_COMPAT: cfg_r.restart_compatible <= cfg_wdata[0];
        CFG_CLAMP_IN_RANGE: cfg_r.clamp_in_range     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // action decode and summary tracking
  ibb_summary u_summary (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (action_t'(in_action)),
    .position  (in_position),
    .vertex    (in_vertex),
    .cfg       (cfg_r),
    .summary   (summary),
    .step      (step),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  // index word store
  ibb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_position[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // compaction of the read word
  ibb_convert u_convert (
    .summary     (summary),
    .cfg         (cfg_r),
    .read_ok     (step_r.read_ok),
    .word        (mem_rdata),
    .read_value  (conv_value),
    .narrow_mode (conv_narrow),
    .index_base  (conv_base),
    .is_empty    (conv_empty)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            step_r  <= step;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          out_valid_r      <= 1'b1;
          out_read_value   <= conv_value;
          out_narrow_mode  <= conv_narrow;
          out_index_base   <= conv_base;
          out_entry_count  <= summary.entry_total;
          out_is_empty     <= conv_empty;
          out_used_restart <= summary.restart_seen;
          out_status       <= step_r.status;
          state_r          <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> tb/index_buffer_builder_compactor_top_test.sv
module index_buffer_builder_compactor_top_test import ibb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the block must ignore
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int IDLE_PCT        = 14;
  localparam int HOLD_OFF_CYCLES = 60;

  // one result word as seen on the out channel
  typedef struct {
    logic [WORD_W-1:0] read_value;
    logic              narrow_mode;
    logic [WORD_W-1:0] index_base;
    logic [CNT_W-1:0]  entry_count;
    logic              is_empty;
    logic              used_restart;
    logic [1:0]        status;
  } index_result_t;

  // shadow of the index store, its summary and registers, plus awaited results
  class compaction_scoreboard;
    logic [WORD_W-1:0] slot_word [STORE_DEPTH];
    bit                slot_written [STORE_DEPTH];
    logic [CNT_W-1:0]  entry_total;
    logic [WORD_W-1:0] lowest;
    logic [WORD_W-1:0] highest;
    bit                restart_seen;
    cfg_t              regs;
    index_result_t     awaited [$];
    int                errors;

    function new();
      errors = 0;
      regs.restart_value      = '1;
      regs.max_vertex         = '1;
      regs.capacity           = DEPTH_CNT;
      regs.restart_compatible = 1'b1;
      regs.clamp_in_range     = 1'b0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_written[i]) slot_written[i] = 1'b0;
      entry_total  = '0;
      lowest       = '1;
      highest      = '0;
      restart_seen = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [WORD_W-1:0] value);
      case (idx)
        CFG_RESTART_VALUE:  regs.restart_value = value;
        CFG_MAX_VERTEX:     regs.max_vertex = value;
        CFG_CAPACITY:       regs.capacity = value[CNT_W-1:0];
        CFG_RESTART_COMPAT: regs.restart_compatible = value[0];
        CFG_CLAMP_IN_RANGE: regs.clamp_in_range = value[0];
        default: ;
      endcase
    endfunction

    function int slot_limit();
      return (regs.capacity > DEPTH_CNT) ? STORE_DEPTH : int'(regs.capacity);
    endfunction

    // span of tracked indices fits the 16-bit range
    function bit is_narrow();
      logic [WORD_W-1:0] span;
      span = (lowest < highest) ? highest - lowest : '0;
      return span <= NARROW_SPAN;
    endfunction

    // 16-bit compaction of a stored word
    function logic [WORD_W-1:0] compact(logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] top;
      logic [WORD_W-1:0] diff;
      if (!is_narrow()) return word;
      if (highest >= NARROW_TOP) begin
        top = (regs.restart_compatible || !regs.clamp_in_range) ?
              NARROW_TOP : highest - lowest;
        diff = word - lowest;
        return (diff < top) ? diff : top;
      end
      return word & NARROW_TOP;
    endfunction

    function void store(int slot, logic [WORD_W-1:0] word);
      slot_word[slot]    = word;
      slot_written[slot] = 1'b1;
      if (slot + 1 > int'(entry_total)) entry_total = CNT_W'(slot + 1);
    endfunction

    // apply one accepted word and queue the result it must produce
    function void note_word(logic [2:0] action, logic [POS_W-1:0] position,
                            logic [WORD_W-1:0] vertex);
      index_result_t r;
      int lim;
      int slot;
      lim = slot_limit();
      r.read_value = '0;
      r.status     = ST_OK;
      case (action)
        ACT_APPEND, ACT_SET_AT: begin
          slot = (action == ACT_APPEND) ? int'(entry_total) : int'(position);
          if (vertex > regs.max_vertex) r.status = ST_VERTEX;
          else if (slot >= lim) r.status = ST_POSITION;
          else begin
            store(slot, vertex);
            if (vertex < lowest) lowest = vertex;
            if (vertex > highest) highest = vertex;
          end
        end
        ACT_APPEND_RESTART, ACT_RESTART_AT: begin
          slot = (action == ACT_APPEND_RESTART) ? int'(entry_total) : int'(position);
          if (slot >= lim) r.status = ST_POSITION;
          else begin
            store(slot, regs.restart_value);
            restart_seen = 1'b1;
          end
        end
        ACT_READ: begin
          if (int'(position) >= lim) r.status = ST_POSITION;
          else r.read_value = compact(slot_word[position]);
        end
        ACT_CLEAR: wipe();
        default: ;
      endcase
      r.narrow_mode  = is_narrow();
      r.index_base   = (r.narrow_mode && highest >= NARROW_TOP) ? lowest : '0;
      r.entry_count  = entry_total;
      r.is_empty     = lowest > highest;
      r.used_restart = restart_seen;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare a result word against the oldest awaited one
    function void check_word(index_result_t got);
      index_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual status %0d value %h",
                 $time, got.status, got.read_value);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("narrow_mode", WORD_W'(want.narrow_mode), WORD_W'(got.narrow_mode));
      compare_field("index_base", want.index_base, got.index_base);
      compare_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
      compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
      compare_field("used_restart", WORD_W'(want.used_restart),
                    WORD_W'(got.used_restart));
      compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_action;
  logic [POS_W-1:0]  in_position;
  logic [WORD_W-1:0] in_vertex;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_read_value;
  logic              out_narrow_mode;
  logic [WORD_W-1:0] out_index_base;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_empty;
  logic              out_used_restart;
  logic [1:0]        out_status;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  compaction_scoreboard sb;
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_off_req   = 1'b0;
  logic [WORD_W-1:0] cluster_base;
  logic [WORD_W-1:0] cluster_spread;

  index_buffer_builder_compactor_top dut (.*);

  always #1 clk = ~clk;

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (receiver_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    index_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.read_value   = out_read_value;
      got.narrow_mode  = out_narrow_mode;
      got.index_base   = out_index_base;
      got.entry_count  = out_entry_count;
      got.is_empty     = out_is_empty;
      got.used_restart = out_used_restart;
      got.status       = out_status;
      sb.check_word(got);
    end
  end

  // offer one word, with random gaps ahead of it, and wait for acceptance
  task automatic send_word(logic [2:0] action, logic [POS_W-1:0] position,
                           logic [WORD_W-1:0] vertex);
    if (!sender_quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_action   <= action;
    in_position <= position;
    in_vertex   <= vertex;
    do @(posedge clk); while (in_stall);
    sb.note_word(action, position, vertex);
  endtask

  // stop offering and wait until every awaited result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(logic [WORD_W-1:0] restart_word, logic [WORD_W-1:0] vertex_limit,
                           logic [CNT_W-1:0] slots, logic compat, logic clamp);
    settle();
    write_reg(CFG_RESTART_VALUE, restart_word);
    write_reg(CFG_MAX_VERTEX, vertex_limit);
    write_reg(CFG_CAPACITY, WORD_W'(slots));
    write_reg(CFG_RESTART_COMPAT, WORD_W'(compat));
    write_reg(CFG_CLAMP_IN_RANGE, WORD_W'(clamp));
  endtask

  // pick a new neighborhood for vertex indices
  task automatic new_cluster();
    case ($urandom_range(0, 3))
      0: begin
        cluster_base   = $urandom_range(0, 32'h0000_F000);
        cluster_spread = 32'h0000_0FFE;
      end
      1: begin
        cluster_base   = $urandom_range(32'h0000_8000, 32'hFFFE_0000);
        cluster_spread = NARROW_SPAN;
      end
      2: begin
        cluster_base   = $urandom_range(32'h0000_8000, 32'hFFFE_0000);
        cluster_spread = NARROW_TOP;
      end
      default: begin
        cluster_base   = $urandom;
        cluster_spread = $urandom_range(16, 32'h0100_0000);
      end
    endcase
  endtask

  // vertex mostly from the cluster, with its ends, the limit and the extremes
  function automatic logic [WORD_W-1:0] pick_vertex();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return cluster_base;
    if (r < 12) return cluster_base + cluster_spread;
    if (r < 80) return cluster_base + $urandom_range(0, cluster_spread);
    if (r < 86) return $urandom;
    if (r < 90) return sb.regs.max_vertex;
    if (r < 94) return sb.regs.max_vertex + 1;
    if (r < 97) return '1;
    return '0;
  endfunction

  // one random action; reads only touch written slots or slots past capacity
  task automatic random_word();
    int pick;
    int lim;
    int pos;
    int top;
    int k;
    bit found;
    logic [WORD_W-1:0] v;
    lim  = sb.slot_limit();
    pick = $urandom_range(0, 99);
    v    = pick_vertex();
    top  = (int'(sb.entry_total) < STORE_DEPTH) ? int'(sb.entry_total) : STORE_DEPTH - 1;
    pos  = ($urandom_range(0, 9) != 0) ? $urandom_range(0, top) :
                                          $urandom_range(0, STORE_DEPTH - 1);
    if (pick < 30) begin
      send_word(ACT_APPEND, POS_W'($urandom), v);
    end else if (pick < 36) begin
      send_word(ACT_APPEND_RESTART, POS_W'($urandom), $urandom);
    end else if (pick < 50) begin
      send_word(ACT_SET_AT, POS_W'(pos), v);
    end else if (pick < 55) begin
      send_word(ACT_RESTART_AT, POS_W'(pos), $urandom);
    end else if (pick < 92) begin
      found = 1'b0;
      if (lim < STORE_DEPTH && $urandom_range(0, 3) == 0) begin
        pos   = $urandom_range(lim, STORE_DEPTH - 1);
        found = 1'b1;
      end else if (sb.entry_total != 0) begin
        for (k = 0; k < 16 && !found; k++) begin
          pos = $urandom_range(0, int'(sb.entry_total) - 1);
          if (pos >= lim || sb.slot_written[pos]) found = 1'b1;
        end
      end
      if (found) send_word(ACT_READ, POS_W'(pos), $urandom);
      else send_word(ACT_APPEND, POS_W'($urandom), v);
    end else if (pick < 96) begin
      new_cluster();
      send_word(ACT_CLEAR, POS_W'($urandom), $urandom);
    end else begin
      send_word($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, POS_W'($urandom),
                $urandom);
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_APPEND;
    in_position = '0;
    in_vertex   = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_RESTART_VALUE;
    cfg_wdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    configure('1, '1, DEPTH_CNT, 1'b1, 1'b0);
    send_word(ACT_APPEND, '0, 32'h0000_0000);
    send_word(ACT_APPEND, '0, 32'hFFFF_FFFF);
    send_word(ACT_READ, 10'd0, '0);
    send_word(ACT_READ, 10'd1, '0);
    send_word(ACT_APPEND_RESTART, '0, '0);
    send_word(ACT_READ, 10'd2, '0);
    send_word(ACT_CLEAR, '0, '0);
    // span of exactly 0xfffe, rebased on the minimum
    send_word(ACT_APPEND, '0, 32'h0001_0000);
    send_word(ACT_APPEND, '0, 32'h0001_FFFE);
    send_word(ACT_READ, 10'd1, '0);
    // rebased restart marker clamps to 0xffff
    send_word(ACT_RESTART_AT, 10'd5, '0);
    send_word(ACT_READ, 10'd5, '0);
    // span one too wide, raw words
    send_word(ACT_APPEND, '0, 32'h0001_FFFF);
    send_word(ACT_READ, 10'd6, '0);
    // last slot, then appends beyond capacity
    send_word(ACT_SET_AT, 10'h3FF, 32'h0000_1234);
    send_word(ACT_APPEND, '0, 32'h0000_0005);
    send_word(ACT_APPEND_RESTART, '0, '0);
    send_word(ACT_SPARE_6, 10'h3FF, 32'hFFFF_FFFF);
    send_word(ACT_SPARE_7, 10'h3FF, 32'hFFFF_FFFF);
    send_word(ACT_CLEAR, '0, '0);
    // low indices truncate, then maximum reaching 0xffff rebases
    send_word(ACT_APPEND, '0, 32'h0000_00FF);
    send_word(ACT_READ, 10'd0, '0);
    send_word(ACT_APPEND, '0, 32'h0000_FFFF);
    send_word(ACT_READ, 10'd1, '0);
    send_word(ACT_CLEAR, '0, '0);

    // defaults, first a stretch with no idling on either side
    new_cluster();
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    repeat (150) random_word();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    repeat (100) random_word();

    // capacity above the store depth, clamp to span for non-restart types
    configure($urandom, 32'hC000_0000, 11'h7FF, 1'b0, 1'b1);
    repeat (150) random_word();

    // small capacity, restart word zero
    configure(32'h0000_0000, 32'hFFFF_FFFE, 11'd16, 1'b0, 1'b0);
    repeat (120) random_word();

    // nothing fits: zero capacity and zero vertex limit
    configure(32'hFFFF_FFFF, 32'h0000_0000, 11'd0, 1'b1, 1'b1);
    repeat (25) random_word();

    // random capacity, with the receiver holding off for a long stretch
    configure($urandom, $urandom | 32'h8000_0000, CNT_W'($urandom_range(1, STORE_DEPTH)),
              1'b1, 1'b1);
    hold_off_req = 1'b1;
    repeat (150) random_word();

    // a single slot
    configure($urandom, 32'hFFFF_FFFF, 11'd1, 1'b0, 1'b1);
    repeat (40) random_word();

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #500_000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> index_buffer_builder_compactor_top.f
hw/rtl/ibb_pkg.sv
hw/rtl/ibb_ram.sv
hw/rtl/ibb_summary.sv
hw/rtl/ibb_convert.sv
hw/rtl/index_buffer_builder_compactor_top.sv
tb/index_buffer_builder_compactor_top_test.sv
